// File: rtl/sdpc_pkg.sv
// types and constants shared by the droplet pair coalescence pipeline
package sdpc_pkg;

	localparam int MULT_W      = 48;
	localparam int RAD_W       = 32;
	localparam int MASS_W      = 48;
	localparam int PROB_W      = 40;
	localparam int FRAC_W      = 16;
	localparam int GAM_W       = 25;
	localparam int PROD_W      = MULT_W + GAM_W;
	localparam int SQ_W        = 2 * RAD_W;
	localparam int CUBE_W      = 3 * RAD_W;
	localparam int SUM_W       = CUBE_W + GAM_W;
	localparam int GAM_STEPS   = GAM_W;
	localparam int ROOT_STEPS  = RAD_W;
	localparam int PREP_STAGES = 6;

	localparam logic [MASS_W-1:0] MASS_MAX = '1;

	typedef struct packed {
		logic [MULT_W-1:0] first_multiplicity;
		logic [MULT_W-1:0] second_multiplicity;
		logic [RAD_W-1:0]  first_radius;
		logic [RAD_W-1:0]  second_radius;
		logic [MASS_W-1:0] first_solute_mass;
		logic [MASS_W-1:0] second_solute_mass;
		logic [PROB_W-1:0] coalescence_probability;
		logic [FRAC_W-1:0] random_fraction;
	} in_t;

	typedef struct packed {
		logic [MULT_W-1:0] new_first_multiplicity;
		logic [MULT_W-1:0] new_second_multiplicity;
		logic [RAD_W-1:0]  new_first_radius;
		logic [RAD_W-1:0]  new_second_radius;
		logic [MASS_W-1:0] new_first_solute_mass;
		logic [MASS_W-1:0] new_second_solute_mass;
		logic              first_became_null;
		logic [MASS_W-1:0] coalesced_count;
	} out_t;

	// gamma search state handed from cell to cell
	typedef struct packed {
		in_t               d;
		logic [GAM_W-1:0]  g0;
		logic [GAM_W-1:0]  g;
		logic [PROD_W-1:0] prod;
	} gam_t;

	// cube root state handed from cell to cell
	typedef struct packed {
		in_t               d;
		logic [GAM_W-1:0]  gam;
		logic [MULT_W-1:0] used;
		logic [MASS_W-1:0] nm;
		logic [SUM_W-1:0]  s;
		logic [RAD_W-1:0]  res;
		logic [SQ_W-1:0]   sq;
		logic [CUBE_W-1:0] cube;
	} root_t;

endpackage

// File: rtl/sdpc_gamma_cell.sv
// one bit of the capped coalescence count search
module sdpc_gamma_cell import sdpc_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic clk,
	input  logic arst_n,
	input  logic en,
	input  logic in_valid,
	input  gam_t d,
	output logic valid_q,
	output gam_t q
);

	logic [GAM_W-1:0]  cand;
	logic [PROD_W-1:0] cprod;
	logic              take;
	gam_t              nxt;

	always_comb begin
		cand  = d.g | (GAM_W'(1) << BIT);
		cprod = d.prod + (PROD_W'(d.d.second_multiplicity) << BIT);
		take  = (cand <= d.g0) && (cprod <= PROD_W'(d.d.first_multiplicity));
		nxt   = d;
		if (take) begin
			nxt.g    = cand;
			nxt.prod = cprod;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// File: rtl/sdpc_prep.sv
// multiply stages: cubes, scaled cube sum and new solute mass
module sdpc_prep import sdpc_pkg::*; (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  gam_t  d,
	output logic  valid_q,
	output root_t q
);

	typedef struct packed {
		in_t               d;
		logic [GAM_W-1:0]  gam;
		logic [MULT_W-1:0] used;
	} car_t;

	localparam int HALF_M = MASS_W / 2;
	localparam int PP_W   = GAM_W + RAD_W;

	logic [PREP_STAGES-1:0] v_q;
	car_t                   c_s1, c_s2, c_s3, c_s4, c_s5;
	logic [SQ_W-1:0]        sq1_s1, sq2_s1;
	logic [GAM_W+HALF_M-1:0] mlo_s1, mhi_s1;
	logic [SQ_W-1:0]        a1lo_s2, a1hi_s2, a2lo_s2, a2hi_s2;
	logic [MASS_W-1:0]      nm_s2, nm_s3, nm_s4, nm_s5;
	logic [CUBE_W-1:0]      c1_s3, c2_s3, c2_s4, c2_s5;
	logic [PP_W-1:0]        p0_s4, p1_s4, p2_s4;
	logic [SUM_W-1:0]       t_s5;
	car_t                   c_in;
	logic [PROD_W-1:0]      mp;
	logic [PROD_W:0]        msum;

	always_comb begin
		c_in.d    = d.d;
		c_in.gam  = (d.d.second_multiplicity == '0) ? '0 : d.g;
		c_in.used = d.prod[MULT_W-1:0];
		mp   = PROD_W'(mlo_s1) + (PROD_W'(mhi_s1) << HALF_M);
		msum = (PROD_W+1)'(c_s1.d.second_solute_mass) + (PROD_W+1)'(mp);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_q <= '0;
		end else if (en) begin
			v_q <= {v_q[PREP_STAGES-2:0], in_valid};
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			c_s1   <= c_in;
			sq1_s1 <= SQ_W'(d.d.first_radius) * SQ_W'(d.d.first_radius);
			sq2_s1 <= SQ_W'(d.d.second_radius) * SQ_W'(d.d.second_radius);
			mlo_s1 <= (GAM_W+HALF_M)'(c_in.gam) *
				(GAM_W+HALF_M)'(d.d.first_solute_mass[HALF_M-1:0]);
			mhi_s1 <= (GAM_W+HALF_M)'(c_in.gam) *
				(GAM_W+HALF_M)'(d.d.first_solute_mass[MASS_W-1:HALF_M]);

			c_s2    <= c_s1;
			a1lo_s2 <= SQ_W'(sq1_s1[RAD_W-1:0]) * SQ_W'(c_s1.d.first_radius);
			a1hi_s2 <= SQ_W'(sq1_s1[SQ_W-1:RAD_W]) * SQ_W'(c_s1.d.first_radius);
			a2lo_s2 <= SQ_W'(sq2_s1[RAD_W-1:0]) * SQ_W'(c_s1.d.second_radius);
			a2hi_s2 <= SQ_W'(sq2_s1[SQ_W-1:RAD_W]) * SQ_W'(c_s1.d.second_radius);
			nm_s2   <= (msum > (PROD_W+1)'(MASS_MAX)) ? MASS_MAX : msum[MASS_W-1:0];

			c_s3  <= c_s2;
			nm_s3 <= nm_s2;
			c1_s3 <= CUBE_W'(a1lo_s2) + (CUBE_W'(a1hi_s2) << RAD_W);
			c2_s3 <= CUBE_W'(a2lo_s2) + (CUBE_W'(a2hi_s2) << RAD_W);

			c_s4  <= c_s3;
			nm_s4 <= nm_s3;
			c2_s4 <= c2_s3;
			p0_s4 <= PP_W'(c_s3.gam) * PP_W'(c1_s3[RAD_W-1:0]);
			p1_s4 <= PP_W'(c_s3.gam) * PP_W'(c1_s3[2*RAD_W-1:RAD_W]);
			p2_s4 <= PP_W'(c_s3.gam) * PP_W'(c1_s3[CUBE_W-1:2*RAD_W]);

			c_s5  <= c_s4;
			nm_s5 <= nm_s4;
			c2_s5 <= c2_s4;
			t_s5  <= SUM_W'(p0_s4) + (SUM_W'(p1_s4) << RAD_W) + (SUM_W'(p2_s4) << (2*RAD_W));

			q.d    <= c_s5.d;
			q.gam  <= c_s5.gam;
			q.used <= c_s5.used;
			q.nm   <= nm_s5;
			q.s    <= t_s5 + SUM_W'(c2_s5);
			q.res  <= '0;
			q.sq   <= '0;
			q.cube <= '0;
		end
	end

	assign valid_q = v_q[PREP_STAGES-1];

endmodule

// File: rtl/sdpc_root_cell.sv
// one bit of the floor cube root, with running square and cube
module sdpc_root_cell import sdpc_pkg::*; #(
	parameter int BIT = 0
) (
	input  logic  clk,
	input  logic  arst_n,
	input  logic  en,
	input  logic  in_valid,
	input  root_t d,
	output logic  valid_q,
	output root_t q
);

	localparam int CW = CUBE_W + 2;

	logic [RAD_W-1:0] cand;
	logic [CW-1:0]    ccube;
	logic [CW-1:0]    sq3;
	logic [CW-1:0]    res3;
	logic             take;
	root_t            nxt;

	always_comb begin
		cand  = d.res | (RAD_W'(1) << BIT);
		sq3   = CW'(d.sq) + (CW'(d.sq) << 1);
		res3  = CW'(d.res) + (CW'(d.res) << 1);
		ccube = CW'(d.cube) + (sq3 << BIT) + (res3 << (2*BIT)) + (CW'(1) << (3*BIT));
		take  = SUM_W'(ccube) <= d.s;
		nxt   = d;
		if (take) begin
			nxt.res  = cand;
			nxt.sq   = d.sq + (SQ_W'(d.res) << (BIT+1)) + (SQ_W'(1) << (2*BIT));
			nxt.cube = ccube[CUBE_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (en) begin
			valid_q <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			q <= nxt;
		end
	end

endmodule

// File: rtl/super_droplet_pair_coalescence.sv
// top level of the super-droplet pair coalescence pipeline
//
//  channel | direction | handshake            | payload
//  in      | into      | in_valid / in_ready  | in_data  (in_t, one droplet pair)
//  out     | out of    | out_valid / out_ready| out_data (out_t, the updated pair)
//
// one request per cycle enters while the skid register is empty; the pipeline has 64
// stages: 25 gamma search cells, 6 multiply stages, 32 cube root cells and one output stage
// reset clears every valid bit; payload registers are not reset
// a stalled result parks in a one-entry skid register, and the whole pipe
// freezes only while that register is occupied
module super_droplet_pair_coalescence import sdpc_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_data,
	output logic out_valid,
	input  logic out_ready,
	output out_t out_data
);

	// pipeline advance: held off only while the skid register holds a result
	logic en;

	// gamma search row
	logic [GAM_STEPS:0] gv;
	gam_t               gd [GAM_STEPS+1];

	// cube root row
	logic [ROOT_STEPS:0] rv;
	root_t               rd [ROOT_STEPS+1];

	// output stage and skid
	logic  last_q;
	out_t  last_data_q;
	logic  skid_q;
	out_t  skid_data_q;
	out_t  res_c;

	assign en       = !skid_q;
	assign in_ready = en;

	// seed the first gamma cell: gamma0 = floor(prob) plus one when phi is
	// below the fractional part, search state empty
	always_comb begin
		gd[0].d    = in_data;
		gd[0].g0   = GAM_W'(in_data.coalescence_probability[PROB_W-1:FRAC_W]) +
			GAM_W'(in_data.random_fraction < in_data.coalescence_probability[FRAC_W-1:0]);
		gd[0].g    = '0;
		gd[0].prod = '0;
	end
	assign gv[0] = in_valid && in_ready;

	// each gamma cell settles one bit of the largest count that stays at or
	// below gamma0 and keeps count*xi2 within xi1 (which is the cap xi1/xi2)
	for (genvar k = 0; k < GAM_STEPS; k++) begin : g_gam
		sdpc_gamma_cell #(
			.BIT(GAM_W - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_valid(gv[k]),
			.d       (gd[k]),
			.valid_q (gv[k+1]),
			.q       (gd[k+1])
		);
	end

	// cubes, gamma times the first cube, the cube sum and the saturated mass
	sdpc_prep u_prep (
		.clk     (clk),
		.arst_n  (arst_n),
		.en      (en),
		.in_valid(gv[GAM_STEPS]),
		.d       (gd[GAM_STEPS]),
		.valid_q (rv[0]),
		.q       (rd[0])
	);

	// each root cell settles one bit of the new radius, most significant first
	for (genvar k = 0; k < ROOT_STEPS; k++) begin : g_root
		sdpc_root_cell #(
			.BIT(RAD_W - 1 - k)
		) u_cell (
			.clk     (clk),
			.arst_n  (arst_n),
			.en      (en),
			.in_valid(rv[k]),
			.d       (rd[k]),
			.valid_q (rv[k+1]),
			.q       (rd[k+1])
		);
	end

	// pick the outcome: pass through, drop2 grows, or twins
	always_comb begin
		root_t r;
		r = rd[ROOT_STEPS];
		res_c.new_first_multiplicity  = r.d.first_multiplicity;
		res_c.new_second_multiplicity = r.d.second_multiplicity;
		res_c.new_first_radius        = r.d.first_radius;
		res_c.new_second_radius       = r.d.second_radius;
		res_c.new_first_solute_mass   = r.d.first_solute_mass;
		res_c.new_second_solute_mass  = r.d.second_solute_mass;
		res_c.first_became_null       = 1'b0;
		res_c.coalesced_count         = MASS_W'(r.gam);
		if (r.gam != '0) begin
			if (r.d.first_multiplicity > r.used) begin
				// drop1 gives up members, drop2 takes the grown radius and mass
				res_c.new_first_multiplicity = r.d.first_multiplicity - r.used;
				res_c.new_second_radius      = r.res;
				res_c.new_second_solute_mass = r.nm;
			end else begin
				// twins split xi2: floor half to drop1, the rest to drop2
				res_c.new_first_multiplicity  = r.d.second_multiplicity >> 1;
				res_c.new_second_multiplicity = r.d.second_multiplicity -
					(r.d.second_multiplicity >> 1);
				res_c.new_first_radius        = r.res;
				res_c.new_second_radius       = r.res;
				res_c.new_first_solute_mass   = r.nm;
				res_c.new_second_solute_mass  = r.nm;
				res_c.first_became_null       = (r.d.second_multiplicity >> 1) == '0;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			last_q <= 1'b0;
			skid_q <= 1'b0;
		end else begin
			if (en) begin
				last_q <= rv[ROOT_STEPS];
			end
			// park the last result when the consumer stalls, release it on ready
			if (skid_q) begin
				if (out_ready) begin
					skid_q <= 1'b0;
				end
			end else if (last_q && !out_ready) begin
				skid_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (en) begin
			last_data_q <= res_c;
		end
		if (!skid_q) begin
			skid_data_q <= last_data_q;
		end
	end

	assign out_valid = skid_q || last_q;
	assign out_data  = skid_q ? skid_data_q : last_data_q;

	// null flag means drop1 ended with no members
	a_null_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.first_became_null) |->
			(out_data.new_first_multiplicity == '0))
		else $error("null flag with nonzero first multiplicity");

	// no coalescence never flags a null drop
	a_no_gamma: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.coalesced_count == '0) |-> !out_data.first_became_null)
		else $error("null flag without coalescence");

	// twins that flag a null drop1 share the new radius
	a_twin_radius: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_data.first_became_null) |->
			(out_data.new_first_radius == out_data.new_second_radius))
		else $error("twin radii differ");

	// the skid register only fills from a valid output stage
	a_skid_src: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(skid_q) |-> $past(last_q))
		else $error("skid filled without a result");

endmodule
